FILE: hw/rtl/p1305_pkg.sv
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants of the poly1305 block accumulator.
// ----------------------------------------------------------------------------
package p1305_pkg;

	// prime 2^130 - 5
	localparam logic [130:0] PRIME = {1'b0, 2'b11, {64{1'b1}}, 64'hffff_ffff_ffff_fffb};

	// operand word width of the shared multiplier
	localparam int unsigned WORD_W = 32;

	// words of the padded accumulator sum and of the key
	localparam int unsigned A_WORDS = 5;
	localparam int unsigned R_WORDS = 4;

	// width of the full product before reduction
	localparam int unsigned PROD_W = 259;

	// control that travels with one partial product
	typedef struct packed {
		logic       vld;
		logic [2:0] pos;
	} mul_tag_t;

endpackage

FILE: hw/rtl/p1305_if.sv
// ----------------------------------------------------------------------------
// p1305 channel interfaces
// Valid/ready channels for message blocks and for finished tags.
// ----------------------------------------------------------------------------
interface p1305_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic        last_block;

	modport source (output valid, block_low, block_high, last_block, input ready);
	modport sink (input valid, block_low, block_high, last_block, output ready);
endinterface

interface p1305_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_low;
	logic [63:0] hash_high;
	logic [1:0]  hash_top;

	modport source (output valid, hash_low, hash_high, hash_top, input ready);
	modport sink (input valid, hash_low, hash_high, hash_top, output ready);
endinterface

FILE: hw/rtl/poly1305_block_accumulator.sv
// ----------------------------------------------------------------------------
// poly1305_block_accumulator
// Absorbs 16-byte blocks into h = (h + m + 2^128) * r mod 2^130-5.
// ----------------------------------------------------------------------------
// A block runs from acceptance through ST_LOAD, then ST_MUL, which feeds the
// single 32x32 multiplier the twenty partial products (five accumulator
// words by four key words), then ST_DRAIN, the fold states ST_RED1 and
// ST_RED2, and ST_FINAL with its compare and subtract, back to ST_IDLE;
// the next block is accepted only there.
// in_ch.ready is high only while the sequencer is idle. A last
// block places the fully reduced 130-bit tag in an output register and
// clears the accumulator; the next block proceeds while that tag waits, and
// only a second last block stalls in its final cycle until the tag is taken.
module poly1305_block_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	p1305_in_if.sink     in_ch,
	p1305_out_if.source  out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_DRAIN, ST_RED1, ST_RED2, ST_FINAL
	} state_t;

	localparam logic CFG_R_LOW  = 1'b0;
	localparam logic CFG_R_HIGH = 1'b1;

	state_t                          state_q;
	logic [127:0]                    key_q;
	logic [127:0]                    blk_q;
	logic                            last_q;
	logic [129:0]                    h_q;
	logic [159:0]                    a_q;
	logic [2:0]                      i_q;
	logic [1:0]                      j_q;
	logic [p1305_pkg::PROD_W-1:0]    acc_q;
	logic [132:0]                    x_q;
	logic                            out_vld_q;
	logic [129:0]                    out_q;

	logic [p1305_pkg::WORD_W-1:0]    op_a;
	logic [p1305_pkg::WORD_W-1:0]    op_b;
	p1305_pkg::mul_tag_t             req;
	logic [2*p1305_pkg::WORD_W-1:0]  prod_s1;
	p1305_pkg::mul_tag_t             rsp_s1;
	logic [p1305_pkg::PROD_W-1:0]    prod_ext;
	logic [130:0]                    x_sub;
	logic [129:0]                    res;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_R_LOW:  key_q[63:0]   <= cfg_data;
				CFG_R_HIGH: key_q[127:64] <= cfg_data;
				default:    key_q         <= key_q;
			endcase
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		op_a    = a_q[{i_q, 5'b0} +: p1305_pkg::WORD_W];
		op_b    = key_q[{j_q, 5'b0} +: p1305_pkg::WORD_W];
		req.vld = (state_q == ST_MUL);
		req.pos = i_q + 3'(j_q);
	end

	p1305_mul32 u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_a    (op_a),
		.op_b    (op_b),
		.req     (req),
		.prod_s1 (prod_s1),
		.rsp_s1  (rsp_s1)
	);

	// partial product placed at its word position
	assign prod_ext = p1305_pkg::PROD_W'(prod_s1) << {rsp_s1.pos, 5'b0};

	// final conditional subtract of the prime
	always_comb begin
		x_sub = x_q[130:0] - p1305_pkg::PRIME;
		res   = (x_q[130:0] >= p1305_pkg::PRIME) ? x_sub[129:0] : x_q[129:0];
	end

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_vld_q;
	assign out_ch.hash_low  = out_q[63:0];
	assign out_ch.hash_high = out_q[127:64];
	assign out_ch.hash_top  = out_q[129:128];

	// sequencer with accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			h_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			last_q    <= 1'b0;
			out_vld_q <= 1'b0;
			blk_q     <= '0;
			a_q       <= '0;
			acc_q     <= '0;
			x_q       <= '0;
			out_q     <= '0;
		end else begin
			// a new tag written in the final cycle keeps the register full
			if (out_ch.valid && out_ch.ready && !(state_q == ST_FINAL && last_q)) begin
				out_vld_q <= 1'b0;
			end
			if (rsp_s1.vld) begin
				acc_q <= acc_q + prod_ext;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						blk_q   <= {in_ch.block_high, in_ch.block_low};
						last_q  <= in_ch.last_block;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// h + m + 2^128
					a_q     <= 160'(h_q) + 160'(blk_q) + (160'(1) << 128);
					acc_q   <= '0;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					j_q <= j_q + 2'd1;
					if (j_q == 2'(p1305_pkg::R_WORDS - 1)) begin
						i_q <= i_q + 3'd1;
						if (i_q == 3'(p1305_pkg::A_WORDS - 1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RED1;
				end
				ST_RED1: begin
					// fold bits from 2^130 back times five
					x_q <= 133'(acc_q[129:0]) + 133'({acc_q[258:130], 2'b0})
						+ 133'(acc_q[258:130]);
					state_q <= ST_RED2;
				end
				ST_RED2: begin
					x_q <= 133'(x_q[129:0]) + 133'({x_q[132:130], 2'b0})
						+ 133'(x_q[132:130]);
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (!last_q) begin
						h_q     <= res;
						state_q <= ST_IDLE;
					end else if (!out_vld_q || out_ch.ready) begin
						out_q     <= res;
						out_vld_q <= 1'b1;
						h_q       <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/p1305_mul32.sv
// ----------------------------------------------------------------------------
// p1305_mul32
// Shared 32x32 multiplier with a registered product and tag.
// ----------------------------------------------------------------------------
module p1305_mul32 (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [p1305_pkg::WORD_W-1:0]           op_a,
	input  logic [p1305_pkg::WORD_W-1:0]           op_b,
	input  p1305_pkg::mul_tag_t                    req,
	output logic [2*p1305_pkg::WORD_W-1:0]         prod_s1,
	output p1305_pkg::mul_tag_t                    rsp_s1
);

	// product register, no reset needed
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// tag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1 <= '0;
		end else begin
			rsp_s1 <= req;
		end
	end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Random and directed test of the poly1305 block accumulator. Blocks go in
// over a valid/ready channel in bursts; a local model predicts the reduced
// tag for each last block and the scoreboard checks every tag in order.
// ----------------------------------------------------------------------------

// expected tags in arrival order
class hash_scoreboard;
	logic [129:0] tag_q[$];
	logic [129:0] acc;
	logic [127:0] key_r;
	int errors;

	function new();
		acc = '0;
		key_r = '0;
		errors = 0;
	endfunction

	// absorb one accepted block; a last block queues its tag
	function void note_block(logic [63:0] lo, logic [63:0] hi, logic last);
		logic [130:0] prime;
		logic [259:0] prod;
		logic [130:0] h;
		prime = {1'b0, 2'b11, {64{1'b1}}, 64'hffff_ffff_ffff_fffb};
		h = {1'b0, acc} + {3'b001, hi, lo};
		prod = h * key_r;
		prod = prod % prime;
		acc = prod[129:0];
		if (last) begin
			tag_q.push_back(acc);
			acc = '0;
		end
	endfunction

	// compare one accepted tag with the oldest expectation
	function void check_hash(logic [63:0] lo, logic [63:0] hi, logic [1:0] top);
		logic [129:0] exp_tag;
		if (tag_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected tag %h_%h_%h", top, hi, lo);
			return;
		end
		exp_tag = tag_q.pop_front();
		if (exp_tag != {top, hi, lo}) begin
			errors++;
			if (errors <= 10)
				$display("tag exp %h got %h", exp_tag, {top, hi, lo});
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	longint      cycles;
	int          gap_left;
	bit          stall_mode;

	p1305_in_if  in_ch ();
	p1305_out_if out_ch ();

	hash_scoreboard sb;

	poly1305_block_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("poly1305_block_accumulator: mismatch");
				$finish;
			end
		end
	end

	// receiver: stall pattern alternates between free running and random
	initial begin
		out_ch.ready = 1'b0;
		stall_mode = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode <= ~stall_mode;
			out_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// result check at each accepted transaction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_hash(out_ch.hash_low, out_ch.hash_high, out_ch.hash_top);
	end

	task automatic write_key(logic [127:0] r);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 1'b0;
		cfg_data <= r[63:0];
		@(posedge clk);
		cfg_index <= 1'b1;
		cfg_data <= r[127:64];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.key_r = r;
	endtask

	// one block transaction, with a random gap between bursts
	task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic last);
		int idle;
		if (gap_left == 0) begin
			gap_left = $urandom_range(1, 12);
			idle = $urandom_range(0, 40);
			if (idle != 0) begin
				in_ch.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		gap_left--;
		in_ch.valid <= 1'b1;
		in_ch.block_low <= lo;
		in_ch.block_high <= hi;
		in_ch.last_block <= last;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_block(lo, hi, last);
	endtask

	// stop sending, wait for all tags, then let a block in flight finish
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.tag_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	function automatic logic [127:0] clamp(logic [127:0] r);
		return r & 128'h0ffffffc0ffffffc0ffffffc0fffffff;
	endfunction

	initial begin
		logic [127:0] keys[6];
		int n;
		sb = new();
		gap_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.block_low = '0;
		in_ch.block_high = '0;
		in_ch.last_block = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero key, then extremes of block and key
		send_block('0, '0, 1'b1);
		drain();
		write_key(clamp('1));
		send_block('0, '0, 1'b0);
		send_block('1, '1, 1'b0);
		send_block('1, '1, 1'b1);
		send_block(64'hffff_ffff_ffff_fffa, '1, 1'b1);
		drain();
		// unclamped keys, all ones pushes the sum near and past p
		write_key('1);
		send_block('1, '1, 1'b0);
		send_block('1, '1, 1'b0);
		send_block('1, '1, 1'b1);
		drain();
		write_key(128'd1);
		send_block(64'hffff_ffff_ffff_fffb, 64'hffff_ffff_ffff_ffff, 1'b1);
		send_block(64'hffff_ffff_ffff_fffa, 64'hffff_ffff_ffff_ffff, 1'b1);
		send_block('0, '0, 1'b1);
		send_block('1, '1, 1'b1);
		drain();

		// random messages under several keys
		keys[0] = clamp({$urandom(), $urandom(), $urandom(), $urandom()});
		keys[1] = {$urandom(), $urandom(), $urandom(), $urandom()};
		keys[2] = '1;
		keys[3] = 128'd0;
		keys[4] = clamp('1);
		keys[5] = {64'h8000_0000_0000_0000, 64'h1};
		for (int k = 0; k < 6; k++) begin
			write_key(keys[k]);
			n = 0;
			while (n < 140) begin
				send_block(rand64(), rand64(), $urandom_range(0, 3) == 0);
				n++;
			end
			send_block(rand64(), rand64(), 1'b1);
			// sender holds off until every tag is back
			drain();
		end

		if (sb.errors == 0)
			$display("poly1305_block_accumulator: match");
		else
			$display("poly1305_block_accumulator: mismatch");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/p1305_pkg.sv
hw/rtl/p1305_if.sv
hw/rtl/p1305_mul32.sv
hw/rtl/poly1305_block_accumulator.sv
tb/sv/tb.sv
